// ===== rtl/ttce_pkg.sv =====
// shared types and constants for the text terminal cursor engine
// item structs, control codes, controller/datapath command and status bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ttce_pkg;

  localparam int CHAR_W    = 8;
  localparam int ROW_W     = 2;
  localparam int COL_W     = 5;
  localparam int CUR_COL_W = 5;
  localparam int CUR_ROW_W = 3;

  // control codes handled by a put
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_CLRLN = 8'h1A;
  localparam logic [CHAR_W-1:0] BLANK      = 8'h20;

  // action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    cell_value;
    logic [CUR_COL_W-1:0] cursor_column;
    logic [CUR_ROW_W-1:0] cursor_row;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec_read;
    logic bs_left;
    logic wr_blank_cur;
    logic put_adv;
    logic put_space;
    logic cr;
    logic lf;
    logic home;
    logic cnt_load_x;
    logic cnt_clear;
    logic cnt_inc;
    logic clr_line_wr;
    logic clr_all_wr;
    logic scroll_step;
    logic scroll_blank;
    logic out_load;
  } ttce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              is_read;
    logic              parked;
    logic [CHAR_W-1:0] code;
    logic              adv_scroll;
    logic              adv_odd;
    logic              lf_scroll;
    logic              cnt_last_line;
    logic              cnt_last_all;
    logic              cnt_copy_end;
    logic              cnt_blank_end;
    logic              out_free;
  } ttce_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ttce_datapath.sv =====
// datapath: screen memory, cursor, sweep counter, item and result registers
// driven by ttce_ctrl commands; uses ttce_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttce_datapath #(
  parameter int SCREEN_WIDTH  = 20,
  parameter int SCREEN_HEIGHT = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ttce_pkg::in_item_t  in_data,
  input  wire                 out_ready,
  output logic                out_valid,
  output ttce_pkg::out_item_t out_data,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,
  input  ttce_pkg::ttce_cmd_t cmd,
  output ttce_pkg::ttce_sts_t sts
);
  import ttce_pkg::*;

  localparam int N        = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int COPY_END = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
  localparam int XW       = $clog2(SCREEN_WIDTH);
  localparam int YW       = $clog2(SCREEN_HEIGHT + 1);
  localparam int AW       = $clog2(N);
  localparam int CW       = $clog2(N + 1);

  logic [CHAR_W-1:0] mem [N];

  in_item_t          item_r;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              lock_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  logic [CHAR_W-1:0] rdata_r;

  logic              x_last, y_last, rd_in_range;
  logic [AW-1:0]     cur_addr, rd_addr;
  logic [CHAR_W-1:0] put_char;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wdata;

  assign x_last      = (x_r == XW'(SCREEN_WIDTH - 1));
  assign y_last      = (y_r == YW'(SCREEN_HEIGHT - 1));
  assign cur_addr    = AW'(32'(y_r) * SCREEN_WIDTH + 32'(x_r));
  assign rd_addr     = AW'(32'(item_r.read_row) * SCREEN_WIDTH + 32'(item_r.read_column));
  assign rd_in_range = (32'(item_r.read_row) < SCREEN_HEIGHT) &&
                       (32'(item_r.read_column) < SCREEN_WIDTH);
  assign put_char    = cmd.put_space ? BLANK : item_r.char_code;

  always_comb begin
    sts               = '0;
    sts.is_read       = (item_r.action == ACT_READ);
    sts.parked        = (32'(y_r) >= SCREEN_HEIGHT);
    sts.code          = item_r.char_code;
    sts.adv_scroll    = x_last && y_last && !lock_r;
    sts.adv_odd       = !x_last && !x_r[0];
    sts.lf_scroll     = y_last && !lock_r;
    sts.cnt_last_line = (cnt_r == CW'(SCREEN_WIDTH - 1));
    sts.cnt_last_all  = (cnt_r == CW'(N - 1));
    sts.cnt_copy_end  = (cnt_r == CW'(COPY_END));
    sts.cnt_blank_end = (cnt_r == CW'(N));
    sts.out_free      = !out_valid_r || out_ready;
  end

  // cursor moves
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cmd.home) begin
      x_nxt = '0;
      y_nxt = '0;
    end
    if (cmd.cr) begin
      x_nxt = '0;
    end
    if (cmd.bs_left && (x_r != '0)) begin
      x_nxt = x_r - XW'(1);
    end
    if (cmd.lf && !y_last) begin
      y_nxt = y_r + YW'(1);
    end
    if (cmd.put_adv) begin
      if (x_last) begin
        x_nxt = '0;
        if (y_last) begin
          // park below the screen when scrolling is locked
          y_nxt = lock_r ? YW'(SCREEN_HEIGHT) : y_r;
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clear) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_load_x) begin
      cnt_nxt = CW'(x_r);
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = BLANK;
    if (cmd.put_adv && (put_char != '0)) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = put_char;
    end
    if (cmd.wr_blank_cur) begin
      we    = 1'b1;
      waddr = cur_addr;
    end
    if (cmd.clr_line_wr) begin
      we    = 1'b1;
      waddr = AW'(32'(y_r) * SCREEN_WIDTH + 32'(cnt_r));
    end
    if (cmd.clr_all_wr) begin
      we    = 1'b1;
      waddr = AW'(cnt_r);
    end
    // scroll copy writes come in the cycle after the matching read
    if (cmd.scroll_step && (cnt_r != '0)) begin
      we    = 1'b1;
      waddr = AW'(cnt_r - CW'(1));
      wdata = rdata_r;
    end
    if (cmd.scroll_blank) begin
      we    = 1'b1;
      waddr = AW'(cnt_r - CW'(1));
    end
  end

  // single read port
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd.exec_read && rd_in_range) begin
      re    = 1'b1;
      raddr = rd_addr;
    end
    if (cmd.scroll_step && (32'(cnt_r) < COPY_END)) begin
      re    = 1'b1;
      raddr = AW'(32'(cnt_r) + SCREEN_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      cnt_r       <= '0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lock_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r.cell_value    <= (sts.is_read && rd_in_range) ? rdata_r : '0;
      out_r.cursor_column <= CUR_COL_W'(x_r);
      out_r.cursor_row    <= CUR_ROW_W'(y_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/ttce_ctrl.sv =====
// controller state machine: decodes each item and sequences the datapath
// issues ttce_cmd_t, reads ttce_sts_t; uses ttce_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttce_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ttce_pkg::ttce_sts_t sts,
  output ttce_pkg::ttce_cmd_t cmd
);
  import ttce_pkg::*;

  localparam logic [3:0] S_RSTCLR   = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_EXEC     = 4'd2;
  localparam logic [3:0] S_TAB2     = 4'd3;
  localparam logic [3:0] S_BSWR     = 4'd4;
  localparam logic [3:0] S_CLRLINE  = 4'd5;
  localparam logic [3:0] S_FFCLR    = 4'd6;
  localparam logic [3:0] S_SCROLL   = 4'd7;
  localparam logic [3:0] S_SCRBLANK = 4'd8;
  localparam logic [3:0] S_RESULT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_RSTCLR: begin
        cmd.clr_all_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (sts.cnt_last_all) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESULT;
        if (sts.is_read) begin
          cmd.exec_read = 1'b1;
        end else if (!sts.parked) begin
          case (sts.code)
            CODE_BS: begin
              cmd.bs_left = 1'b1;
              state_nxt   = S_BSWR;
            end
            CODE_TAB: begin
              cmd.put_adv   = 1'b1;
              cmd.put_space = 1'b1;
              if (sts.adv_scroll) begin
                cmd.cnt_clear = 1'b1;
                state_nxt     = S_SCROLL;
              end else if (sts.adv_odd) begin
                state_nxt = S_TAB2;
              end
            end
            CODE_CR: begin
              cmd.cr = 1'b1;
            end
            CODE_LF: begin
              cmd.lf = 1'b1;
              if (sts.lf_scroll) begin
                cmd.cnt_clear = 1'b1;
                state_nxt     = S_SCROLL;
              end
            end
            CODE_FF: begin
              cmd.home      = 1'b1;
              cmd.cnt_clear = 1'b1;
              state_nxt     = S_FFCLR;
            end
            CODE_CLRLN: begin
              cmd.cnt_load_x = 1'b1;
              state_nxt      = S_CLRLINE;
            end
            default: begin
              cmd.put_adv = 1'b1;
              if (sts.adv_scroll) begin
                cmd.cnt_clear = 1'b1;
                state_nxt     = S_SCROLL;
              end
            end
          endcase
        end
      end
      S_TAB2: begin
        // cursor is on an odd column: one more space reaches even or wraps
        cmd.put_adv   = 1'b1;
        cmd.put_space = 1'b1;
        if (sts.adv_scroll) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = S_SCROLL;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_BSWR: begin
        cmd.wr_blank_cur = 1'b1;
        state_nxt        = S_RESULT;
      end
      S_CLRLINE: begin
        cmd.clr_line_wr = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_last_line) begin
          state_nxt = S_RESULT;
        end
      end
      S_FFCLR: begin
        cmd.clr_all_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (sts.cnt_last_all) begin
          state_nxt = S_RESULT;
        end
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_copy_end) begin
          state_nxt = S_SCRBLANK;
        end
      end
      S_SCRBLANK: begin
        cmd.scroll_blank = 1'b1;
        cmd.cnt_inc      = 1'b1;
        if (sts.cnt_blank_end) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RSTCLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_cursor_engine.sv =====
// top level of the text terminal cursor engine
// joins ttce_ctrl and ttce_datapath; uses ttce_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
//   in channel: one item per valid/ready handshake; action put draws or handles
//   a control byte at the cursor, action read fetches one screen cell
//   out channel: exactly one item per input item, in order, holding the read
//   cell (0 on puts) and the cursor position after the item
//   cfg_wr_en/cfg_wr_data: scroll lock bit, to be written only when idle; the block leaves this unchecked
// sequence, one item at a time
//   each item passes through the idle (accept), exec and result states, and its
//   result is loaded in the result state, once the output register is free
//   backspace adds a state that blanks the new cursor cell; a tab from an even
//   column adds a state for its second space (the tab writes two spaces)
//   clear to end of line: blanks from the cursor column to the end of the row
//   form feed: homes the cursor and clears the screen, one cell cleared per cycle
//   scroll (line feed or wrap at the bottom, unlocked): rows are copied up a line
//   one cell per cycle by the single memory write port, then the last row blanked
// reset
//   the screen memory is swept to spaces, one cell per cycle, all
//   SCREEN_WIDTH*SCREEN_HEIGHT cells (80 by default); in_ready stays low
// stall
//   a waiting result sits in the output register; the next item can be taken
//   and worked on, and its result waits until the register is free
module text_terminal_cursor_engine #(
  parameter int SCREEN_WIDTH  = 20,
  parameter int SCREEN_HEIGHT = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ttce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ttce_pkg::out_item_t out_data,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data
);
  import ttce_pkg::*;

  // command and status bundles between the two halves
  ttce_cmd_t cmd;
  ttce_sts_t sts;

  // sequencer: decodes the item, runs sweeps for clear and scroll
  ttce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // screen memory, cursor registers and result register
  ttce_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/ttce_checker.sv =====
// port-level checks for text_terminal_cursor_engine, bound to the top level
// uses ttce_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttce_checker #(
  parameter int SCREEN_WIDTH  = 20,
  parameter int SCREEN_HEIGHT = 4
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input ttce_pkg::out_item_t out_data
);
  import ttce_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // reported column is on screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.cursor_column) < SCREEN_WIDTH)
    else $error("cursor column off screen");

  // parked cursor sits at column zero
  a_park_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (32'(out_data.cursor_row) == SCREEN_HEIGHT) |->
      out_data.cursor_column == '0)
    else $error("parked cursor not at column zero");

endmodule

bind text_terminal_cursor_engine ttce_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ttce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
